// ===== src/ira_pkg.sv =====
// Package of the incidence rarefaction accumulator: default widths, register
// indexes and the command struct passed from the sequencer to the multiply-divide unit.
// No dependencies.
`default_nettype none

package ira_pkg;

  localparam int unsigned UNIT_WIDTH         = 16;
  localparam int unsigned SPECIES_WIDTH      = 24;
  localparam int unsigned PROB_FRACTION_BITS = 32;
  localparam int unsigned SUM_WIDTH          = 48;
  localparam int unsigned CFG_INDEX_WIDTH    = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOTAL_UNITS    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUBSAMPLE_SIZE = 2'd1;

  // Command to the multiply-divide unit.
  typedef struct packed {
    logic start;
    logic divide;
  } ira_cmd_t;

endpackage

`default_nettype wire

// ===== src/ira_muldiv.sv =====
// Iterative multiply-divide unit: floor(x*y/d) or x*y, one bit per cycle.
// Depends on ira_pkg for the command struct.
`default_nettype none

module ira_muldiv #(
  parameter int unsigned XW = 33,
  parameter int unsigned YW = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ira_pkg::ira_cmd_t    cmd_i,
  input  wire logic [XW-1:0]        x_i,
  input  wire logic [YW-1:0]        y_i,
  input  wire logic [YW-1:0]        d_i,
  output logic                      done_o,
  output logic [XW+YW-1:0]          prod_o
);
  import ira_pkg::*;

  localparam int unsigned PW   = XW + YW;
  localparam int unsigned MAXW = (XW > YW) ? XW : YW;
  localparam int unsigned CW   = $clog2(MAXW + 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } ustate_e;

  ustate_e         state_q;
  logic [CW-1:0]   cnt_q;
  logic [PW-1:0]   acc_q;
  logic [XW-1:0]   xs_q;
  logic [YW-1:0]   ys_q;
  logic [YW-1:0]   d_q;
  logic            div_q;
  logic            done_q;

  logic [PW-1:0]   mul_next;
  logic [YW:0]     rem_sh;
  logic            ge;
  logic [YW:0]     rem_diff;
  logic [PW-1:0]   div_next;

  // Shift-add multiply, most significant multiplier bit first.
  assign mul_next = {acc_q[PW-2:0], 1'b0} + (ys_q[YW-1] ? PW'(xs_q) : '0);

  // Restoring division step. The upper YW bits hold the partial remainder,
  // which starts below the divisor; quotient bits shift in at the bottom.
  assign rem_sh   = {acc_q[PW-1:XW], acc_q[XW-1]};
  assign ge       = rem_sh >= {1'b0, d_q};
  assign rem_diff = rem_sh - {1'b0, d_q};
  always_comb begin
    div_next = {acc_q[PW-1:XW], acc_q[XW-2:0], ge};
    if (ge) begin
      div_next[PW-1:XW] = rem_diff[YW-1:0];
    end else begin
      div_next[PW-1:XW] = rem_sh[YW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      div_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            state_q <= U_MUL;
            cnt_q   <= CW'(YW - 1);
            div_q   <= cmd_i.divide;
          end
        end
        U_MUL: begin
          if (cnt_q == '0) begin
            if (div_q) begin
              state_q <= U_DIV;
              cnt_q   <= CW'(XW - 1);
            end else begin
              state_q <= U_IDLE;
              done_q  <= 1'b1;
            end
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        U_DIV: begin
          if (cnt_q == '0) begin
            state_q <= U_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && cmd_i.start) begin
      acc_q <= '0;
      xs_q  <= x_i;
      ys_q  <= y_i;
      d_q   <= d_i;
    end else if (state_q == U_MUL) begin
      acc_q <= mul_next;
      ys_q  <= {ys_q[YW-2:0], 1'b0};
    end else if (state_q == U_DIV) begin
      acc_q <= div_next;
    end
  end

  assign done_o = done_q;
  assign prod_o = div_q ? PW'(acc_q[XW-1:0]) : acc_q;

endmodule

`default_nettype wire

// ===== src/incidence_rarefaction_accumulator.sv =====
// Top level of the incidence rarefaction accumulator: configuration registers,
// sequencer, running sum and output register. Uses ira_pkg and ira_muldiv.
`default_nettype none

// Each item is one frequency class (incidence frequency f, species count n and a
// last-class mark). For each class the block forms the absence probability
// p = prod_{j<t} (T-f-j)/(T-j) in unsigned Q1.PROB_FRACTION_BITS, truncating after
// every factor, and adds (1-p)*n truncated to unsigned 32.16 to a running sum. When
// f exceeds T or T-f is smaller than t, p is zero and the class counts fully.
// On a class marked last the block delivers the sum and a sticky saturation flag
// as one result item and clears both; other classes deliver nothing. The sum
// saturates at 2^48-1. All arithmetic runs through one iterative multiply-divide
// unit: each factor is a multiply over Y = max(UNIT_WIDTH, SPECIES_WIDTH) bits
// followed by a divide of X = PROB_FRACTION_BITS+1 quotient bits, and the final
// weighting is a multiply only. The product stops early once p reaches zero. The
// input is stalled while an item is in work; a finished result waits in its output
// register while the next items are taken. Configuration writes are accepted at
// any time but must only be made while the block is idle; indexes beyond the two
// registers are ignored.
module incidence_rarefaction_accumulator #(
  parameter int unsigned UNIT_WIDTH         = ira_pkg::UNIT_WIDTH,
  parameter int unsigned SPECIES_WIDTH      = ira_pkg::SPECIES_WIDTH,
  parameter int unsigned PROB_FRACTION_BITS = ira_pkg::PROB_FRACTION_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write channel.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ira_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [UNIT_WIDTH-1:0]               cfg_data_i,
  // Input channel: one frequency class per item.
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [UNIT_WIDTH-1:0]               class_frequency_i,
  input  wire logic [SPECIES_WIDTH-1:0]            class_species_i,
  input  wire logic                                last_class_i,
  // Output channel: one result item per set of classes.
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [ira_pkg::SUM_WIDTH-1:0]            expected_richness_o,
  output logic                                     saturated_o
);
  import ira_pkg::*;

  localparam int unsigned XW = PROB_FRACTION_BITS + 1;
  localparam int unsigned YW = (UNIT_WIDTH > SPECIES_WIDTH) ? UNIT_WIDTH : SPECIES_WIDTH;
  localparam int unsigned PW = XW + YW;
  localparam int unsigned TW = (PW > SUM_WIDTH) ? PW : SUM_WIDTH + 1;
  localparam int unsigned SHIFT = PROB_FRACTION_BITS - 16;
  localparam logic [XW-1:0] PROB_ONE = {1'b1, {PROB_FRACTION_BITS{1'b0}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_STEP,
    S_TERM,
    S_TERM_WAIT,
    S_ACCUM
  } state_e;

  state_e                  state_q;
  logic [UNIT_WIDTH-1:0]   total_q;
  logic [UNIT_WIDTH-1:0]   subs_q;
  logic [UNIT_WIDTH-1:0]   freq_q;
  logic [SPECIES_WIDTH-1:0] species_q;
  logic                    last_q;
  logic [UNIT_WIDTH-1:0]   n_q;
  logic [UNIT_WIDTH-1:0]   j_q;
  logic [XW-1:0]           p_q;
  logic [SUM_WIDTH-1:0]    sum_q;
  logic                    sat_q;
  logic                    out_valid_q;
  logic [SUM_WIDTH-1:0]    out_sum_q;
  logic                    out_sat_q;

  ira_cmd_t                cmd;
  logic [XW-1:0]           op_x;
  logic [YW-1:0]           op_y;
  logic [YW-1:0]           op_d;
  logic                    unit_done;
  logic [PW-1:0]           unit_prod;

  logic                    in_accept;
  logic                    cfg_write;
  logic [UNIT_WIDTH-1:0]   n_calc;
  logic                    prob_zero;
  logic                    loop_go;
  logic [TW-1:0]           term_wide;
  logic                    term_over;
  logic [SUM_WIDTH:0]      sum_ext;
  logic [SUM_WIDTH-1:0]    new_sum;
  logic                    new_sat;
  logic                    out_blocked;
  logic                    out_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // Remaining units and the two cases in which the product is zero.
  assign n_calc    = total_q - freq_q;
  assign prob_zero = (freq_q > total_q) || (n_calc < subs_q);

  // Another factor is due while j < t and the product has not died out.
  assign loop_go = (j_q != subs_q) && (p_q != '0);

  // Operands of the shared unit: a factor step in S_LOOP, the weighting in S_TERM.
  always_comb begin
    cmd.start  = 1'b0;
    cmd.divide = 1'b0;
    op_x       = PROB_ONE - p_q;
    op_y       = YW'(species_q);
    op_d       = YW'(total_q - j_q);
    if (state_q == S_LOOP) begin
      cmd.start  = loop_go;
      cmd.divide = 1'b1;
      op_x       = p_q;
      op_y       = YW'(n_q - j_q);
    end else if (state_q == S_TERM) begin
      cmd.start = 1'b1;
    end
  end

  ira_muldiv #(
    .XW (XW),
    .YW (YW)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (op_x),
    .y_i    (op_y),
    .d_i    (op_d),
    .done_o (unit_done),
    .prod_o (unit_prod)
  );

  // Truncate the weighted term to 32.16, then add it with saturation.
  assign term_wide = TW'(unit_prod) >> SHIFT;
  assign term_over = term_wide > TW'(SUM_MAX);
  assign sum_ext   = {1'b0, sum_q} + {1'b0, term_wide[SUM_WIDTH-1:0]};
  assign new_sat   = sat_q || term_over || sum_ext[SUM_WIDTH];
  assign new_sum   = (term_over || sum_ext[SUM_WIDTH]) ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];

  // A last class waits in S_ACCUM while the previous result is still held.
  assign out_blocked = out_valid_q && out_stall_i;
  assign out_load    = (state_q == S_ACCUM) && last_q && !out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= UNIT_WIDTH'(1);
      subs_q      <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_i)
          CFG_TOTAL_UNITS:    total_q <= cfg_data_i;
          CFG_SUBSAMPLE_SIZE: subs_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // A new result replaces one that leaves in the same cycle.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_q <= prob_zero ? S_TERM : S_LOOP;
        end
        S_LOOP: begin
          state_q <= loop_go ? S_STEP : S_TERM;
        end
        S_STEP: begin
          if (unit_done) begin
            state_q <= S_LOOP;
          end
        end
        S_TERM: begin
          state_q <= S_TERM_WAIT;
        end
        S_TERM_WAIT: begin
          if (unit_done) begin
            state_q <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (!last_q) begin
            sum_q   <= new_sum;
            sat_q   <= new_sat;
            state_q <= S_IDLE;
          end else if (!out_blocked) begin
            sum_q   <= '0;
            sat_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      freq_q    <= class_frequency_i;
      species_q <= class_species_i;
      last_q    <= last_class_i;
    end
    if (state_q == S_CHECK) begin
      n_q <= n_calc;
      j_q <= '0;
      p_q <= prob_zero ? '0 : PROB_ONE;
    end else if (state_q == S_STEP && unit_done) begin
      p_q <= unit_prod[XW-1:0];
      j_q <= j_q + 1'b1;
    end
    if (out_load) begin
      out_sum_q <= new_sum;
      out_sat_q <= new_sat;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign expected_richness_o = out_sum_q;
  assign saturated_o         = out_sat_q;

endmodule

`default_nettype wire
